@@ sv/max_heap_priority_queue_defines.svh @@
// Assertion macros shared by the heap queue RTL.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define MHPQ_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MHPQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MHPQ_ASSERT_IMPL(name, ante, cons, msg)
`define MHPQ_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

@@ sv/mhpq_pkg.sv @@
package mhpq_pkg;

    localparam int DEPTH     = 1024;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CAP_W     = 11;
    localparam int VAL_W     = 32;
    localparam int ACT_W     = 2;
    localparam int ST_W      = 2;
    localparam int OUT_CNT_W = 11;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT  = 2'd0,
        ACT_REMOVE  = 2'd1,
        ACT_APPEND  = 2'd2,
        ACT_HEAPIFY = 2'd3
    } t_action;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

endpackage

@@ sv/mhpq_in_if.sv @@
interface mhpq_in_if;
    logic                              valid;
    logic                              ready;
    logic [mhpq_pkg::ACT_W-1:0]        action;
    logic signed [mhpq_pkg::VAL_W-1:0] value;

    modport source (output valid, action, value, input ready);
    modport sink   (input valid, action, value, output ready);
endinterface

@@ sv/mhpq_out_if.sv @@
interface mhpq_out_if;
    logic                              valid;
    logic                              ready;
    logic [mhpq_pkg::ST_W-1:0]         status;
    logic signed [mhpq_pkg::VAL_W-1:0] max_value;
    logic [mhpq_pkg::OUT_CNT_W-1:0]    entry_count_out;

    modport source (output valid, status, max_value, entry_count_out, input ready);
    modport sink   (input valid, status, max_value, entry_count_out, output ready);
endinterface

@@ sv/mhpq_ram.sv @@
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/max_heap_priority_queue.sv @@
// Binary max-heap priority queue of signed 32-bit values, held in one 1024 x 32 RAM with
// a single write port and a single registered read port. Each input item is an action:
// insert, remove maximum, append unordered, or heapify; each yields exactly one result
// item with a status (ok, full, empty), the removed maximum (zero unless a remove
// succeeds) and the entry count afterwards. The block takes one item at a time and holds
// ready low until that item's result sits in the output register, which can wait for the
// consumer while the next item is already accepted. All work goes through the one RAM
// read port and one shared signed comparator, so an item's run time grows with the heap
// height L (at most 10): a refused item or an append goes straight to its result, an
// insert reads and compares one parent per level it climbs, a remove reads the root and
// the last entry and then sifts down over the height left after the removal, and a
// heapify runs one sift-down per inner node, reading and comparing per level it descends.
// The capacity register (reset 1024, clamped to 1024) may be rewritten only while idle.
`include "max_heap_priority_queue_defines.svh"

module max_heap_priority_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mhpq_pkg::CAP_W-1:0]   i_cfg_wdata,
    mhpq_in_if.sink                      i_in,
    mhpq_out_if.source                   o_out
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_RM_ROOT,
        S_RM_LAST,
        S_HP_RD,
        S_HP_GOT,
        S_SD_CHK,
        S_SD_RC,
        S_SD_RC1,
        S_SD_DEC,
        S_DONE
    } t_state;

    t_state                              r_state, n_state;
    logic [mhpq_pkg::ACT_W-1:0]          r_act, n_act;
    logic [mhpq_pkg::VAL_W-1:0]          r_val, n_val;
    logic [mhpq_pkg::CNT_W-1:0]          r_count, n_count;
    logic [mhpq_pkg::CNT_W-1:0]          r_pos, n_pos;
    logic [mhpq_pkg::CNT_W-1:0]          r_child, n_child;
    logic [mhpq_pkg::CNT_W-1:0]          r_hidx, n_hidx;
    logic [mhpq_pkg::VAL_W-1:0]          r_cval, n_cval;
    logic [mhpq_pkg::VAL_W-1:0]          r_mov, n_mov;
    logic [mhpq_pkg::ST_W-1:0]           r_res_status, n_res_status;
    logic [mhpq_pkg::VAL_W-1:0]          r_res_max, n_res_max;
    logic [mhpq_pkg::CAP_W-1:0]          r_capacity, n_capacity;
    logic                                r_o_valid, n_o_valid;
    logic [mhpq_pkg::ST_W-1:0]           r_o_status, n_o_status;
    logic [mhpq_pkg::VAL_W-1:0]          r_o_max, n_o_max;
    logic [mhpq_pkg::OUT_CNT_W-1:0]      r_o_cnt, n_o_cnt;

    logic                                ram_we;
    logic [mhpq_pkg::ADDR_W-1:0]         ram_waddr;
    logic [mhpq_pkg::VAL_W-1:0]          ram_wdata;
    logic [mhpq_pkg::ADDR_W-1:0]         ram_raddr;
    logic [mhpq_pkg::VAL_W-1:0]          ram_rdata;

    logic signed [mhpq_pkg::VAL_W-1:0]   cmp_a;
    logic signed [mhpq_pkg::VAL_W-1:0]   cmp_b;
    logic                                cmp_le;

    logic [mhpq_pkg::CNT_W+mhpq_pkg::CAP_W-1:0] cap_wide;
    logic [mhpq_pkg::CNT_W+mhpq_pkg::CAP_W-1:0] depth_wide;
    logic [mhpq_pkg::CNT_W-1:0]          cap_eff;
    logic [mhpq_pkg::CNT_W:0]            child_wide;
    logic                                is_fill;

    mhpq_ram #(
        .WIDTH (mhpq_pkg::VAL_W),
        .DEPTH (mhpq_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Capacity is clamped to the store depth.
    assign cap_wide   = (mhpq_pkg::CNT_W + mhpq_pkg::CAP_W)'(r_capacity);
    assign depth_wide = (mhpq_pkg::CNT_W + mhpq_pkg::CAP_W)'(mhpq_pkg::DEPTH);
    assign cap_eff    = (cap_wide < depth_wide) ? mhpq_pkg::CNT_W'(cap_wide)
                                                : mhpq_pkg::CNT_W'(depth_wide);

    assign child_wide = {r_pos, 1'b0};
    assign is_fill    = (i_in.action == mhpq_pkg::ACT_INSERT) ||
                        (i_in.action == mhpq_pkg::ACT_APPEND);

    // The one comparator: a <= b, signed, with operands chosen by state.
    always_comb begin
        case (r_state)
            S_INS_CMP: begin
                cmp_a = $signed(ram_rdata);
                cmp_b = $signed(r_val);
            end
            S_SD_RC1: begin
                cmp_a = $signed(ram_rdata);
                cmp_b = $signed(r_cval);
            end
            S_SD_DEC: begin
                cmp_a = $signed(r_cval);
                cmp_b = $signed(r_mov);
            end
            default: begin
                cmp_a = $signed(ram_rdata);
                cmp_b = $signed(r_val);
            end
        endcase
    end

    assign cmp_le = (cmp_a <= cmp_b);

    always_comb begin
        n_state      = r_state;
        n_act        = r_act;
        n_val        = r_val;
        n_count      = r_count;
        n_pos        = r_pos;
        n_child      = r_child;
        n_hidx       = r_hidx;
        n_cval       = r_cval;
        n_mov        = r_mov;
        n_res_status = r_res_status;
        n_res_max    = r_res_max;
        n_o_valid    = r_o_valid;
        n_o_status   = r_o_status;
        n_o_max      = r_o_max;
        n_o_cnt      = r_o_cnt;
        n_capacity   = i_cfg_we ? i_cfg_wdata : r_capacity;
        ram_we       = 1'b0;
        ram_waddr    = mhpq_pkg::ADDR_W'(r_pos - 1'b1);
        ram_wdata    = r_mov;
        ram_raddr    = '0;

        if (r_o_valid && o_out.ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_act        = i_in.action;
                    n_val        = i_in.value;
                    n_res_status = mhpq_pkg::ST_OK;
                    n_res_max    = '0;
                    if (is_fill) begin
                        if (r_count >= cap_eff) begin
                            n_res_status = mhpq_pkg::ST_FULL;
                            n_state      = S_DONE;
                        end else begin
                            n_count = r_count + 1'b1;
                            n_pos   = r_count + 1'b1;
                            if (i_in.action == mhpq_pkg::ACT_APPEND) begin
                                ram_we    = 1'b1;
                                ram_waddr = mhpq_pkg::ADDR_W'(r_count);
                                ram_wdata = i_in.value;
                                n_state   = S_DONE;
                            end else begin
                                n_state = S_INS_RD;
                            end
                        end
                    end else if (i_in.action == mhpq_pkg::ACT_REMOVE) begin
                        if (r_count == '0) begin
                            n_res_status = mhpq_pkg::ST_EMPTY;
                            n_state      = S_DONE;
                        end else begin
                            ram_raddr = '0;
                            n_state   = S_RM_ROOT;
                        end
                    end else begin
                        n_hidx = r_count >> 1;
                        if ((r_count >> 1) == '0) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_HP_RD;
                        end
                    end
                end
            end
            S_INS_RD: begin
                if (r_pos == mhpq_pkg::CNT_W'(1)) begin
                    ram_we    = 1'b1;
                    ram_wdata = r_val;
                    n_state   = S_DONE;
                end else begin
                    ram_raddr = mhpq_pkg::ADDR_W'((r_pos >> 1) - 1'b1);
                    n_state   = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                ram_we = 1'b1;
                if (cmp_le) begin
                    // The parent is not larger, so it moves down one level.
                    ram_wdata = ram_rdata;
                    n_pos     = r_pos >> 1;
                    n_state   = S_INS_RD;
                end else begin
                    ram_wdata = r_val;
                    n_state   = S_DONE;
                end
            end
            S_RM_ROOT: begin
                n_res_max = ram_rdata;
                ram_raddr = mhpq_pkg::ADDR_W'(r_count - 1'b1);
                n_state   = S_RM_LAST;
            end
            S_RM_LAST: begin
                n_mov   = ram_rdata;
                n_count = r_count - 1'b1;
                n_pos   = mhpq_pkg::CNT_W'(1);
                if (r_count == mhpq_pkg::CNT_W'(1)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SD_CHK;
                end
            end
            S_HP_RD: begin
                ram_raddr = mhpq_pkg::ADDR_W'(r_hidx - 1'b1);
                n_state   = S_HP_GOT;
            end
            S_HP_GOT: begin
                n_mov   = ram_rdata;
                n_pos   = r_hidx;
                n_state = S_SD_CHK;
            end
            S_SD_CHK: begin
                if (child_wide > {1'b0, r_count}) begin
                    // No child left: the moving entry settles here.
                    ram_we = 1'b1;
                    if ((r_act == mhpq_pkg::ACT_HEAPIFY) &&
                        (r_hidx != mhpq_pkg::CNT_W'(1))) begin
                        n_hidx  = r_hidx - 1'b1;
                        n_state = S_HP_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_child   = mhpq_pkg::CNT_W'(child_wide);
                    ram_raddr = mhpq_pkg::ADDR_W'(child_wide - 1'b1);
                    n_state   = S_SD_RC;
                end
            end
            S_SD_RC: begin
                n_cval = ram_rdata;
                if (r_child < r_count) begin
                    ram_raddr = mhpq_pkg::ADDR_W'(r_child);
                    n_state   = S_SD_RC1;
                end else begin
                    n_state = S_SD_DEC;
                end
            end
            S_SD_RC1: begin
                // The right child wins only when strictly larger.
                if (!cmp_le) begin
                    n_child = r_child + 1'b1;
                    n_cval  = ram_rdata;
                end
                n_state = S_SD_DEC;
            end
            S_SD_DEC: begin
                ram_we = 1'b1;
                if (cmp_le) begin
                    ram_wdata = r_mov;
                    if ((r_act == mhpq_pkg::ACT_HEAPIFY) &&
                        (r_hidx != mhpq_pkg::CNT_W'(1))) begin
                        n_hidx  = r_hidx - 1'b1;
                        n_state = S_HP_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    ram_wdata = r_cval;
                    n_pos     = r_child;
                    n_state   = S_SD_CHK;
                end
            end
            S_DONE: begin
                if (!r_o_valid || o_out.ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_max    = r_res_max;
                    n_o_cnt    = mhpq_pkg::OUT_CNT_W'(r_count);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_capacity <= mhpq_pkg::CAP_RESET;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_capacity <= n_capacity;
            r_o_valid  <= n_o_valid;
        end
        r_act        <= n_act;
        r_val        <= n_val;
        r_pos        <= n_pos;
        r_child      <= n_child;
        r_hidx       <= n_hidx;
        r_cval       <= n_cval;
        r_mov        <= n_mov;
        r_res_status <= n_res_status;
        r_res_max    <= n_res_max;
        r_o_status   <= n_o_status;
        r_o_max      <= n_o_max;
        r_o_cnt      <= n_o_cnt;
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_o_valid;
    assign o_out.status          = r_o_status;
    assign o_out.max_value       = r_o_max;
    assign o_out.entry_count_out = r_o_cnt;

    `MHPQ_ASSERT_IMPL(a_count_bound, 1'b1,
        r_count <= mhpq_pkg::CNT_W'(mhpq_pkg::DEPTH),
        "entry count above depth")
    `MHPQ_ASSERT_IMPL(a_fail_zero_max,
        r_o_valid && (r_o_status != mhpq_pkg::ST_OK),
        r_o_max == '0,
        "nonzero maximum on a refused item")
    `MHPQ_ASSERT_NEXT(a_empty_remove,
        (r_state == S_IDLE) && i_in.valid && (i_in.action == mhpq_pkg::ACT_REMOVE) &&
            (r_count == '0),
        (r_state == S_DONE) && (r_res_status == mhpq_pkg::ST_EMPTY),
        "remove from empty heap not reported")
    `MHPQ_ASSERT_NEXT(a_full_keeps_count,
        (r_state == S_IDLE) && i_in.valid && is_fill && (r_count >= cap_eff),
        $stable(r_count) && (r_res_status == mhpq_pkg::ST_FULL),
        "refused fill changed the count")
    `MHPQ_ASSERT_IMPL(a_sift_pos, r_state == S_SD_CHK,
        (r_pos != '0) && (r_pos <= r_count),
        "sift position outside the heap")

endmodule

@@ sim/tb_max_heap_priority_queue.sv @@
`timescale 1ns / 1ps

module tb_max_heap_priority_queue;

    localparam int DEPTH          = mhpq_pkg::DEPTH;
    localparam int VAL_W          = mhpq_pkg::VAL_W;
    localparam int CAP_W          = mhpq_pkg::CAP_W;
    localparam int OUT_CNT_W      = mhpq_pkg::OUT_CNT_W;
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 60;

    typedef struct packed {
        mhpq_pkg::t_status          status;
        logic signed [VAL_W-1:0]    maxv;
        logic [OUT_CNT_W-1:0]       cnt;
    } t_heap_res;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;
    typedef enum logic {BY_MODEL, TYPED} t_row_check;

    typedef struct packed {
        t_row_kind          kind;
        mhpq_pkg::t_action  act;
        logic [VAL_W-1:0]   value;
        t_row_check         chk;
        t_heap_res          res;
    } t_dir_row;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic [CAP_W-1:0]   cap;
        t_idle_mode         idle;
        logic [11:0]        items;
        logic [6:0]         add_pct;
        logic [6:0]         rem_pct;
        logic               hold;
    } t_phase;

    localparam t_heap_res NO_RES = '{mhpq_pkg::ST_OK, 32'sh0, 11'd0};

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CAP_W-1:0] i_cfg_wdata;

    mhpq_in_if  in_if ();
    mhpq_out_if out_if ();

    max_heap_priority_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // Shadow heap, one-based like the tree it mirrors.
    logic signed [VAL_W-1:0] heap_mem [1:DEPTH];
    int unsigned heap_cnt;
    logic [CAP_W-1:0] cap_reg;

    t_heap_res pending_results [$];

    int src_idle_pct;
    int snk_stall_pct;
    bit hold_go;

    int err_cnt;
    int items_sent;
    int results_seen;
    int cap_writes;
    int peak_cnt;
    int full_cnt;
    int empty_cnt;
    int heapify_cnt;
    int idle_cycles;

    t_dir_row dir_tab [24] = '{
        '{ROW_ITEM, mhpq_pkg::ACT_REMOVE, 32'h0000_0000, TYPED,
          '{mhpq_pkg::ST_EMPTY, 32'sh0, 11'd0}},
        '{ROW_ITEM, mhpq_pkg::ACT_HEAPIFY, 32'h0000_0000, TYPED,
          '{mhpq_pkg::ST_OK, 32'sh0, 11'd0}},
        '{ROW_ITEM, mhpq_pkg::ACT_INSERT, 32'h7FFF_FFFF, TYPED,
          '{mhpq_pkg::ST_OK, 32'sh0, 11'd1}},
        '{ROW_ITEM, mhpq_pkg::ACT_HEAPIFY, 32'h0000_0000, TYPED,
          '{mhpq_pkg::ST_OK, 32'sh0, 11'd1}},
        '{ROW_ITEM, mhpq_pkg::ACT_INSERT, 32'h8000_0000, TYPED,
          '{mhpq_pkg::ST_OK, 32'sh0, 11'd2}},
        '{ROW_ITEM, mhpq_pkg::ACT_INSERT,  32'h8000_0000, BY_MODEL, NO_RES},
        '{ROW_ITEM, mhpq_pkg::ACT_APPEND,  32'h7FFF_FFFF, BY_MODEL, NO_RES},
        '{ROW_ITEM, mhpq_pkg::ACT_APPEND,  32'h0000_0000, BY_MODEL, NO_RES},
        '{ROW_ITEM, mhpq_pkg::ACT_INSERT,  32'h7FFF_FFFF, BY_MODEL, NO_RES},
        '{ROW_ITEM, mhpq_pkg::ACT_INSERT,  32'hFFFF_FFFF, BY_MODEL, NO_RES},
        '{ROW_ITEM, mhpq_pkg::ACT_APPEND,  32'h5555_5555, BY_MODEL, NO_RES},
        '{ROW_ITEM, mhpq_pkg::ACT_APPEND,  32'hAAAA_AAAA, BY_MODEL, NO_RES},
        '{ROW_ITEM, mhpq_pkg::ACT_HEAPIFY, 32'h0000_0000, BY_MODEL, NO_RES},
        '{ROW_ITEM, mhpq_pkg::ACT_REMOVE, 32'h0000_0000, TYPED,
          '{mhpq_pkg::ST_OK, 32'sh7FFF_FFFF, 11'd8}},
        '{ROW_ITEM, mhpq_pkg::ACT_REMOVE, 32'h0000_0000, TYPED,
          '{mhpq_pkg::ST_OK, 32'sh7FFF_FFFF, 11'd7}},
        '{ROW_CFG,  mhpq_pkg::ACT_INSERT, 32'd0, BY_MODEL, NO_RES},
        '{ROW_ITEM, mhpq_pkg::ACT_INSERT, 32'h0000_0001, TYPED,
          '{mhpq_pkg::ST_FULL, 32'sh0, 11'd7}},
        '{ROW_ITEM, mhpq_pkg::ACT_APPEND, 32'h0000_0001, TYPED,
          '{mhpq_pkg::ST_FULL, 32'sh0, 11'd7}},
        '{ROW_CFG,  mhpq_pkg::ACT_INSERT, 32'd3, BY_MODEL, NO_RES},
        '{ROW_ITEM, mhpq_pkg::ACT_INSERT, 32'h0000_0003, TYPED,
          '{mhpq_pkg::ST_FULL, 32'sh0, 11'd7}},
        '{ROW_ITEM, mhpq_pkg::ACT_REMOVE, 32'h0000_0000, BY_MODEL, NO_RES},
        '{ROW_CFG,  mhpq_pkg::ACT_INSERT, 32'd2047,      BY_MODEL, NO_RES},
        '{ROW_ITEM, mhpq_pkg::ACT_INSERT, 32'h0000_0002, BY_MODEL, NO_RES},
        '{ROW_ITEM, mhpq_pkg::ACT_REMOVE, 32'h0000_0000, BY_MODEL, NO_RES}
    };

    // The large phases fill the heap to its full depth; the last one lowers the
    // capacity below the fill level and mostly removes entries.
    t_phase phase_tab [8] = '{
        '{11'd1,    IDLE_NONE, 12'd60,  7'd45, 7'd45, 1'b0},
        '{11'd0,    IDLE_SRC,  12'd30,  7'd50, 7'd40, 1'b0},
        '{11'd2,    IDLE_SNK,  12'd60,  7'd50, 7'd40, 1'b0},
        '{11'd13,   IDLE_BOTH, 12'd120, 7'd55, 7'd35, 1'b0},
        '{11'd64,   IDLE_NONE, 12'd250, 7'd55, 7'd40, 1'b1},
        '{11'd2047, IDLE_NONE, 12'd600, 7'd96, 7'd2,  1'b0},
        '{11'd1024, IDLE_BOTH, 12'd520, 7'd94, 7'd3,  1'b0},
        '{11'd300,  IDLE_SNK,  12'd200, 7'd15, 7'd83, 1'b0}
    };

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Move the entry down from pos, always toward the larger child, and stop at a
    // child that is not larger than it.
    function automatic void heap_sift_down(int unsigned pos,
                                           logic signed [VAL_W-1:0] moving);
        int unsigned p;
        int unsigned c;
        p = pos;
        while (2 * p <= heap_cnt) begin
            c = 2 * p;
            if (c < heap_cnt && heap_mem[c + 1] > heap_mem[c]) begin
                c = c + 1;
            end
            if (heap_mem[c] <= moving) begin
                break;
            end
            heap_mem[p] = heap_mem[c];
            p = c;
        end
        heap_mem[p] = moving;
    endfunction

    function automatic t_heap_res heap_apply(mhpq_pkg::t_action act,
                                             logic signed [VAL_W-1:0] v);
        t_heap_res r;
        int unsigned lim;
        int unsigned i;
        logic signed [VAL_W-1:0] last;
        lim = (cap_reg < DEPTH) ? cap_reg : DEPTH;
        r.status = mhpq_pkg::ST_OK;
        r.maxv = '0;
        case (act)
            mhpq_pkg::ACT_INSERT, mhpq_pkg::ACT_APPEND: begin
                if (heap_cnt >= lim) begin
                    r.status = mhpq_pkg::ST_FULL;
                    full_cnt++;
                end else begin
                    heap_cnt++;
                    i = heap_cnt;
                    // An inserted value climbs past parents that are equal to it.
                    if (act == mhpq_pkg::ACT_INSERT) begin
                        while (i > 1 && heap_mem[i / 2] <= v) begin
                            heap_mem[i] = heap_mem[i / 2];
                            i = i / 2;
                        end
                    end
                    heap_mem[i] = v;
                end
            end
            mhpq_pkg::ACT_REMOVE: begin
                if (heap_cnt == 0) begin
                    r.status = mhpq_pkg::ST_EMPTY;
                    empty_cnt++;
                end else begin
                    last = heap_mem[heap_cnt];
                    r.maxv = heap_mem[1];
                    heap_cnt--;
                    if (heap_cnt > 0) begin
                        heap_sift_down(1, last);
                    end
                end
            end
            default: begin
                heapify_cnt++;
                for (i = heap_cnt / 2; i >= 1; i--) begin
                    heap_sift_down(i, heap_mem[i]);
                end
            end
        endcase
        r.cnt = OUT_CNT_W'(heap_cnt);
        if (heap_cnt > peak_cnt) begin
            peak_cnt = heap_cnt;
        end
        return r;
    endfunction

    task automatic send_item(mhpq_pkg::t_action act, logic signed [VAL_W-1:0] v,
                             t_row_check chk, t_heap_res typed_res);
        t_heap_res pred;
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.action <= act;
        in_if.value  <= v;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pred = heap_apply(act, v);
        pending_results.push_back((chk == TYPED) ? typed_res : pred);
        items_sent++;
    endtask

    // The capacity may only change while the block holds no item.
    task automatic write_capacity(logic [CAP_W-1:0] c);
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= c;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cap_reg = c;
        cap_writes++;
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return $urandom_range(6) - 3;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int r;
        mhpq_pkg::t_action act;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= '0;
        in_if.valid  <= 1'b0;
        in_if.action <= mhpq_pkg::ACT_INSERT;
        in_if.value  <= '0;
        heap_cnt      = 0;
        cap_reg       = mhpq_pkg::CAP_RESET;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            if (dir_tab[k].kind == ROW_CFG) begin
                write_capacity(dir_tab[k].value[CAP_W-1:0]);
            end else begin
                send_item(dir_tab[k].act, dir_tab[k].value, dir_tab[k].chk, dir_tab[k].res);
            end
        end

        foreach (phase_tab[p]) begin
            write_capacity(phase_tab[p].cap);
            case (phase_tab[p].idle)
                IDLE_SRC:  begin src_idle_pct = 70; snk_stall_pct = 0;  end
                IDLE_SNK:  begin src_idle_pct = 0;  snk_stall_pct = 70; end
                IDLE_BOTH: begin src_idle_pct = 24; snk_stall_pct = 24; end
                default:   begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            endcase
            if (phase_tab[p].hold) begin
                hold_go = 1'b1;
            end
            repeat (phase_tab[p].items) begin
                r = $urandom_range(99);
                if (r < phase_tab[p].add_pct) begin
                    act = ($urandom_range(9) < 7) ? mhpq_pkg::ACT_INSERT
                                                  : mhpq_pkg::ACT_APPEND;
                end else if (r < phase_tab[p].add_pct + phase_tab[p].rem_pct) begin
                    act = mhpq_pkg::ACT_REMOVE;
                end else begin
                    act = mhpq_pkg::ACT_HEAPIFY;
                end
                send_item(act, pick_value(), BY_MODEL, NO_RES);
            end
        end

        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Summary: %0d items over %0d capacity settings, %0d results checked, %s%0d.",
                 items_sent, cap_writes, results_seen, "peak fill ", peak_cnt);
        $display("Summary: %0d full refusals, %0d empty refusals, %0d heapify runs, %0d errors.",
                 full_cnt, empty_cnt, heapify_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Result consumer: random stalls, plus one long hold-off while items keep coming.
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                hold_go = 1'b0;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_heap_res got;
        t_heap_res want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = {out_if.status, out_if.max_value, out_if.entry_count_out};
            results_seen++;
            if (pending_results.size() == 0) begin
                err_cnt++;
                $display("%t unexpected result: status %0d max %0d count %0d", $realtime,
                         got.status, got.maxv, got.cnt);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    err_cnt++;
                    $display("%t mismatch: expected status %0d max %0d count %0d,",
                             $realtime, want.status, want.maxv, want.cnt);
                    $display("%t    actual status %0d max %0d count %0d",
                             $realtime, got.status, got.maxv, got.cnt);
                end
            end
        end
    end

    // A cycle counts as idle when neither side moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%t no progress for %0d cycles, %0d results outstanding", $realtime,
                     idle_cycles, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
